@@ rtl/core/clr_pkg.sv @@
package clr_pkg;

	localparam int unsigned SEED_W  = 32;
	localparam int unsigned STATE_W = 31;
	localparam int unsigned LIMIT_W = 16;
	localparam int unsigned MUL_A_W = 32;
	localparam int unsigned MUL_B_W = 16;
	localparam int unsigned ACC_W   = MUL_A_W + MUL_B_W;

	// moduli are 2^31 - fold constant, so hi*2^31 + lo == hi*fold + lo (mod m)
	localparam logic [STATE_W-1:0] MOD_FIRST  = 31'd2147483563;
	localparam logic [STATE_W-1:0] MOD_SECOND = 31'd2147483399;
	localparam logic [STATE_W-1:0] RAW_ADJ    = 31'd2147483562;

	localparam logic [MUL_B_W-1:0] MUL_FIRST   = 16'd40014;
	localparam logic [MUL_B_W-1:0] MUL_SECOND  = 16'd40692;
	localparam logic [MUL_B_W-1:0] FOLD_FIRST  = 16'd85;
	localparam logic [MUL_B_W-1:0] FOLD_SECOND = 16'd249;
	localparam logic [MUL_B_W-1:0] SEED_SCALE  = 16'h0423;
	localparam logic [SEED_W-1:0]  SEED_OFFSET = 32'h0000_0011;

	localparam logic [SEED_W-1:0]  SEED_RST   = 32'd1;
	localparam logic [STATE_W-1:0] FIRST_RST  = 31'd1;
	localparam logic [STATE_W-1:0] SECOND_RST = 31'd1076;

	typedef enum logic {
		ALU_MAC,
		ALU_RED
	} alu_op_t;

	typedef struct packed {
		alu_op_t            op;
		logic [MUL_A_W-1:0] a;
		logic [MUL_B_W-1:0] b;
		logic [ACC_W-1:0]   c;
	} alu_req_t;

	typedef struct packed {
		logic             ge;
		logic [ACC_W-1:0] res;
	} alu_rsp_t;

endpackage

@@ rtl/core/clr_alu.sv @@
module clr_alu import clr_pkg::*; (
	input  alu_req_t req,
	output alu_rsp_t rsp
);

	logic [ACC_W-1:0] prod;
	logic [ACC_W-1:0] modv;

	// MAC: a*b + c. RED: one conditional subtract of modulus a from c.
	always_comb begin
		prod    = ACC_W'(req.a) * ACC_W'(req.b);
		modv    = ACC_W'(req.a);
		rsp.ge  = (req.c >= modv);
		case (req.op)
			ALU_MAC: rsp.res = prod + req.c;
			ALU_RED: rsp.res = rsp.ge ? (req.c - modv) : req.c;
			default: rsp.res = req.c;
		endcase
	end

endmodule

@@ rtl/core/clr_div.sv @@
module clr_div import clr_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  logic [STATE_W-1:0] dividend,
	input  logic [LIMIT_W-1:0] divisor,
	output logic               done,
	output logic [LIMIT_W-1:0] rem
);

	// two remainder bits per cycle
	localparam int unsigned NUM_W = STATE_W + (STATE_W % 2);
	localparam int unsigned STEPS = NUM_W / 2;
	localparam int unsigned CNT_W = $clog2(STEPS);

	logic [NUM_W-1:0]   num_q;
	logic [LIMIT_W-1:0] den_q;
	logic [LIMIT_W-1:0] rem_q;
	logic [CNT_W-1:0]   cnt_q;
	logic               busy_q;
	logic               done_q;

	logic [LIMIT_W:0]   t0, t1;
	logic [LIMIT_W-1:0] r0, r1;

	always_comb begin
		t0 = {rem_q, num_q[NUM_W-1]};
		r0 = (t0 >= {1'b0, den_q}) ? LIMIT_W'(t0 - {1'b0, den_q}) : t0[LIMIT_W-1:0];
		t1 = {r0, num_q[NUM_W-2]};
		r1 = (t1 >= {1'b0, den_q}) ? LIMIT_W'(t1 - {1'b0, den_q}) : t1[LIMIT_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			num_q  <= '0;
			den_q  <= '0;
			rem_q  <= '0;
			cnt_q  <= '0;
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else if (start) begin
			num_q  <= NUM_W'(dividend);
			den_q  <= divisor;
			rem_q  <= '0;
			cnt_q  <= '0;
			busy_q <= 1'b1;
			done_q <= 1'b0;
		end else if (busy_q) begin
			num_q <= {num_q[NUM_W-3:0], 2'b00};
			rem_q <= r1;
			cnt_q <= cnt_q + 1'b1;
			if (cnt_q == CNT_W'(STEPS - 1)) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end else begin
			done_q <= 1'b0;
		end
	end

	assign done = done_q;
	assign rem  = (den_q == '0) ? '0 : rem_q;

endmodule

@@ rtl/core/combined_lcg_random_range_unit.sv @@
// Combined two-seed multiplicative random generator with range reduction.
// Input channel (in_valid/in_stall, limit): one transaction requests one
// random number. Output channel (out_valid/out_stall, value, raw): one
// transaction per request; raw is the combined generator output, value is
// raw mod limit (0 when limit is 0).
// One shared multiply-add / compare-subtract unit is stepped through both
// seed updates (multiply, fold of the high part, then conditional
// subtracts of the modulus until each seed is reduced), then a radix-4
// remainder unit computes the 31-bit modulo by limit. A request is taken
// only once the last one has left the sequencer; in_stall is high whenever
// the sequencer is not idle.
// A finished result sits in the output register; the next request is taken
// meanwhile, and if out_stall still holds when that one finishes the
// sequencer waits in its last state until the register frees up.
// Reset: seed register is 1, seeds are 1 and 1076, block idle.
// A cfg_wen write of the seed reloads both seeds through the shared unit,
// which stalls the input until both seeds are loaded and reduced.
module combined_lcg_random_range_unit import clr_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_wen,
	input  logic [SEED_W-1:0]  cfg_wdata,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic [LIMIT_W-1:0] limit,
	output logic               out_valid,
	input  logic               out_stall,
	output logic [LIMIT_W-1:0] value,
	output logic [STATE_W-1:0] raw
);

	typedef enum logic [3:0] {
		S_IDLE,
		S_LD_MUL,
		S_LD2_RED,
		S_LD1_RED,
		S_A_MUL,
		S_A_FOLD,
		S_A_RED,
		S_B_MUL,
		S_B_FOLD,
		S_B_RED,
		S_COMB,
		S_DIV,
		S_OUT
	} state_t;

	state_t             state_q;
	logic [SEED_W-1:0]  seed_q;
	logic [STATE_W-1:0] s0_q;
	logic [STATE_W-1:0] s1_q;
	logic [ACC_W-1:0]   acc_q;
	logic [LIMIT_W-1:0] lim_q;
	logic [STATE_W-1:0] raw_q;
	logic               out_valid_q;
	logic [LIMIT_W-1:0] value_q;
	logic [STATE_W-1:0] raw_out_q;

	alu_req_t alu_req;
	alu_rsp_t alu_rsp;

	logic [STATE_W:0]   z_diff;
	logic               z_low;
	logic [STATE_W-1:0] raw_next;

	logic               div_start;
	logic               div_done;
	logic [LIMIT_W-1:0] div_rem;

	logic               out_load;

	// shared unit operand select
	always_comb begin
		alu_req = '0;
		case (state_q)
			S_LD_MUL: begin
				alu_req.op = ALU_MAC;
				alu_req.a  = seed_q;
				alu_req.b  = SEED_SCALE;
				alu_req.c  = ACC_W'(SEED_OFFSET);
			end
			S_LD2_RED, S_B_RED: begin
				alu_req.op = ALU_RED;
				alu_req.a  = MUL_A_W'(MOD_SECOND);
				alu_req.c  = acc_q;
			end
			S_LD1_RED, S_A_RED: begin
				alu_req.op = ALU_RED;
				alu_req.a  = MUL_A_W'(MOD_FIRST);
				alu_req.c  = acc_q;
			end
			S_A_MUL: begin
				alu_req.op = ALU_MAC;
				alu_req.a  = MUL_A_W'(s0_q);
				alu_req.b  = MUL_FIRST;
			end
			S_B_MUL: begin
				alu_req.op = ALU_MAC;
				alu_req.a  = MUL_A_W'(s1_q);
				alu_req.b  = MUL_SECOND;
			end
			// product = hi*2^31 + lo; fold hi back in as hi*(2^31 mod m)
			S_A_FOLD: begin
				alu_req.op = ALU_MAC;
				alu_req.a  = MUL_A_W'(acc_q[ACC_W-2:STATE_W]);
				alu_req.b  = FOLD_FIRST;
				alu_req.c  = ACC_W'(acc_q[STATE_W-1:0]);
			end
			S_B_FOLD: begin
				alu_req.op = ALU_MAC;
				alu_req.a  = MUL_A_W'(acc_q[ACC_W-2:STATE_W]);
				alu_req.b  = FOLD_SECOND;
				alu_req.c  = ACC_W'(acc_q[STATE_W-1:0]);
			end
			default: alu_req = '0;
		endcase
	end

	clr_alu u_alu (
		.req (alu_req),
		.rsp (alu_rsp)
	);

	// combine: z = s0 - s1, wrapped into 1..m1-1
	always_comb begin
		z_diff   = {1'b0, s0_q} - {1'b0, s1_q};
		z_low    = z_diff[STATE_W] || (z_diff == '0);
		raw_next = z_low ? (z_diff[STATE_W-1:0] + RAW_ADJ) : z_diff[STATE_W-1:0];
	end

	assign div_start = (state_q == S_COMB);

	clr_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (raw_next),
		.divisor  (lim_q),
		.done     (div_done),
		.rem      (div_rem)
	);

	// result moves into the output register once that register is free
	assign out_load = (state_q == S_OUT) && !cfg_wen && (!out_valid_q || !out_stall);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			seed_q      <= SEED_RST;
			s0_q        <= FIRST_RST;
			s1_q        <= SECOND_RST;
			acc_q       <= '0;
			lim_q       <= '0;
			raw_q       <= '0;
			out_valid_q <= 1'b0;
			value_q     <= '0;
			raw_out_q   <= '0;
		end else begin
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			if (cfg_wen) begin
				// reseed restarts the load sequence
				seed_q  <= cfg_wdata;
				state_q <= S_LD_MUL;
			end else begin
				case (state_q)
					S_IDLE: begin
						if (in_valid) begin
							lim_q   <= limit;
							state_q <= S_A_MUL;
						end
					end
					S_LD_MUL: begin
						// derived seed keeps only the low 32 bits
						acc_q   <= ACC_W'(alu_rsp.res[SEED_W-1:0]);
						state_q <= S_LD2_RED;
					end
					S_LD2_RED: begin
						if (alu_rsp.ge) begin
							acc_q <= alu_rsp.res;
						end else begin
							s1_q    <= acc_q[STATE_W-1:0];
							acc_q   <= ACC_W'(seed_q);
							state_q <= S_LD1_RED;
						end
					end
					S_LD1_RED: begin
						if (alu_rsp.ge) begin
							acc_q <= alu_rsp.res;
						end else begin
							s0_q    <= acc_q[STATE_W-1:0];
							state_q <= S_IDLE;
						end
					end
					S_A_MUL: begin
						acc_q   <= alu_rsp.res;
						state_q <= S_A_FOLD;
					end
					S_A_FOLD: begin
						acc_q   <= alu_rsp.res;
						state_q <= S_A_RED;
					end
					S_A_RED: begin
						if (alu_rsp.ge) begin
							acc_q <= alu_rsp.res;
						end else begin
							s0_q    <= acc_q[STATE_W-1:0];
							state_q <= S_B_MUL;
						end
					end
					S_B_MUL: begin
						acc_q   <= alu_rsp.res;
						state_q <= S_B_FOLD;
					end
					S_B_FOLD: begin
						acc_q   <= alu_rsp.res;
						state_q <= S_B_RED;
					end
					S_B_RED: begin
						if (alu_rsp.ge) begin
							acc_q <= alu_rsp.res;
						end else begin
							s1_q    <= acc_q[STATE_W-1:0];
							state_q <= S_COMB;
						end
					end
					S_COMB: begin
						raw_q   <= raw_next;
						state_q <= S_DIV;
					end
					S_DIV: begin
						if (div_done) begin
							state_q <= S_OUT;
						end
					end
					S_OUT: begin
						// hold until the output register is free
						if (out_load) begin
							value_q   <= div_rem;
							raw_out_q <= raw_q;
							state_q   <= S_IDLE;
						end
					end
					default: state_q <= S_IDLE;
				endcase
			end
		end
	end

	assign in_stall  = (state_q != S_IDLE) || cfg_wen;
	assign out_valid = out_valid_q;
	assign value     = value_q;
	assign raw       = raw_out_q;

	// seeds always stay reduced
	assert property (@(posedge clk) disable iff (!arst_n)
		(s0_q < MOD_FIRST) && (s1_q < MOD_SECOND))
		else $error("seed register not reduced below its modulus");

	// combined output lies in 1..m1-1
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> ((raw != '0) && (raw <= RAW_ADJ)))
		else $error("raw output out of range");

	// remainder unit finishes only while the sequencer waits for it
	assert property (@(posedge clk) disable iff (!arst_n)
		div_done |-> (state_q == S_DIV))
		else $error("remainder done outside wait state");

	// remainder is below the limit, or zero for a zero limit
	assert property (@(posedge clk) disable iff (!arst_n)
		div_done |-> (((lim_q == '0) && (div_rem == '0)) || (div_rem < lim_q)))
		else $error("remainder not below limit");

endmodule

@@ tb/sv/testbench.sv @@
// Block-level testbench for the combined two-seed random range unit.
// Inputs change on the falling edge. Handshakes and outputs are sampled on the rising edge.
module testbench;
	import clr_pkg::*;

	// 1920 requests in all: 238 random ones per seed setting below, plus 16 directed ones in the first.
	localparam int PHASES         = 8;
	localparam int ITEMS_PER_PHASE = 238;
	localparam int HOLD_CYCLES     = 400;
	localparam int DRAIN_CYCLES    = 40;
	// The run limit allows several times the slowest correct requests, counting
	// the time in the block, the sender gap and the receiver stall.
	localparam int CYCLE_LIMIT     = 700000;

	// Keeps its own copy of both generator seeds and a queue of the results
	// still to arrive.
	class draw_scoreboard;
		logic [STATE_W-1:0] first_seed;
		logic [STATE_W-1:0] second_seed;
		logic [LIMIT_W-1:0] value_due[$];
		logic [STATE_W-1:0] raw_due[$];
		int errors;
		int checked;

		function new();
			errors  = 0;
			checked = 0;
			reload_seeds(SEED_RST);
		endfunction

		// Seed write: the first seed is taken modulo its modulus. The second
		// seed is scaled and offset in 32 bits, then taken modulo its modulus.
		function void reload_seeds(logic [SEED_W-1:0] s);
			longint unsigned wide;
			longint unsigned derived;
			wide        = longint'(s);
			derived     = (wide * longint'(SEED_SCALE) + longint'(SEED_OFFSET)) & 64'hFFFF_FFFF;
			first_seed  = STATE_W'(wide % longint'(MOD_FIRST));
			second_seed = STATE_W'(derived % longint'(MOD_SECOND));
		endfunction

		// One accepted request: step both seeds, combine them and reduce by limit.
		function void note_request(logic [LIMIT_W-1:0] lim);
			longint unsigned f;
			longint unsigned g;
			longint z;
			logic [STATE_W-1:0] r;
			f = (longint'(first_seed) * longint'(MUL_FIRST)) % longint'(MOD_FIRST);
			g = (longint'(second_seed) * longint'(MUL_SECOND)) % longint'(MOD_SECOND);
			first_seed  = STATE_W'(f);
			second_seed = STATE_W'(g);
			z = longint'(f) - longint'(g);
			// A difference below one wraps up into the range 1 to 2^31-86.
			if (z < 1) begin
				z = z + longint'(RAW_ADJ);
			end
			r = STATE_W'(z);
			raw_due.push_back(r);
			// A zero limit returns a value of 0. No division is made.
			if (lim == '0) begin
				value_due.push_back('0);
			end else begin
				value_due.push_back(LIMIT_W'(longint'(r) % longint'(lim)));
			end
		endfunction

		function void check_draw(logic [LIMIT_W-1:0] v, logic [STATE_W-1:0] r);
			logic [LIMIT_W-1:0] ev;
			logic [STATE_W-1:0] er;
			if (raw_due.size() == 0) begin
				$display("%0t: unexpected result, value %0d raw %0d", $time, v, r);
				errors++;
				return;
			end
			ev = value_due.pop_front();
			er = raw_due.pop_front();
			checked++;
			if (v !== ev) begin
				$display("%0t: value mismatch, expected %0d, actual %0d", $time, ev, v);
				errors++;
			end
			if (r !== er) begin
				$display("%0t: raw mismatch, expected %0d, actual %0d", $time, er, r);
				errors++;
			end
		endfunction

		function int pending();
			return raw_due.size();
		endfunction
	endclass

	logic               clk;
	logic               arst_n;
	logic               cfg_wen;
	logic [SEED_W-1:0]  cfg_wdata;
	logic               in_valid;
	logic               in_stall;
	logic [LIMIT_W-1:0] limit;
	logic               out_valid;
	logic               out_stall;
	logic [LIMIT_W-1:0] value;
	logic [STATE_W-1:0] raw;

	draw_scoreboard sb;
	int  cycles;
	int  requests;
	int  stall_left;  // receiver stall still owed before the next result
	int  hold_left;   // long receiver hold-off. The receiver process counts it down.
	bit  no_idle;     // phase with no gaps on either side

	combined_lcg_random_range_unit i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wen   (cfg_wen),
		.cfg_wdata (cfg_wdata),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.limit     (limit),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.value     (value),
		.raw       (raw)
	);

	initial clk = 1'b0;
	always #6 clk = ~clk;

	// Watchdog. It also counts cycles for the run limit.
	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("Timeout after %0d cycles, %0d results outstanding", cycles, sb.pending());
			$display("Simulation FAILED");
			$finish;
		end
	end

	// Gap before each transaction: often none, otherwise drawn at random; none in a no_idle phase.
	function automatic int draw_wait();
		if (no_idle || $urandom_range(3) == 0) begin
			return 0;
		end
		return $urandom_range(0, 17);
	endfunction

	// Limits: zero, tiny, near full scale, powers of two, and full random.
	function automatic logic [LIMIT_W-1:0] draw_limit();
		case ($urandom_range(7))
			0: return '0;
			1: return LIMIT_W'($urandom_range(1, 16));
			2: return LIMIT_W'($urandom_range(16'hFF00, 16'hFFFF));
			3: return LIMIT_W'(1) << $urandom_range(15);
			default: return LIMIT_W'($urandom);
		endcase
	endfunction

	// Monitors. A seed write, an accepted request and an accepted result
	// update the scoreboard at the edge where each happens.
	always @(posedge clk) begin
		if (arst_n) begin
			if (cfg_wen) begin
				sb.reload_seeds(cfg_wdata);
			end
			if (in_valid && !in_stall) begin
				sb.note_request(limit);
				requests++;
			end
			if (out_valid && !out_stall) begin
				sb.check_draw(value, raw);
				stall_left = draw_wait();
			end
		end
	end

	// Receiver. It stalls for the drawn count after each result. A long
	// hold-off, once armed, takes priority over that count.
	initial begin
		out_stall <= 1'b0;
		forever begin
			@(negedge clk);
			if (hold_left > 0) begin
				out_stall <= 1'b1;
				hold_left--;
			end else if (stall_left > 0) begin
				out_stall <= 1'b1;
				stall_left--;
			end else begin
				out_stall <= 1'b0;
			end
		end
	end

	// Offers one request after a gap. It returns at the falling edge that
	// follows acceptance. in_valid stays high when the next gap is zero.
	task automatic send_request(logic [LIMIT_W-1:0] lim);
		int gap;
		gap = draw_wait();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid <= 1'b1;
		limit    <= lim;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		@(negedge clk);
	endtask

	// The seed is written only once the block is idle: no results are
	// outstanding and the latency has passed.
	task automatic write_seed(logic [SEED_W-1:0] s);
		while (sb.pending() != 0) @(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
		cfg_wen   <= 1'b1;
		cfg_wdata <= s;
		@(negedge clk);
		cfg_wen   <= 1'b0;
	endtask

	initial begin
		logic [SEED_W-1:0]  phase_seed[PHASES];
		logic [LIMIT_W-1:0] directed[16];
		logic [SEED_W-1:0]  inv;

		arst_n     <= 1'b0;
		cfg_wen    <= 1'b0;
		cfg_wdata  <= '0;
		in_valid   <= 1'b0;
		limit      <= '0;
		cycles     = 0;
		requests   = 0;
		stall_left = 0;
		hold_left  = 0;
		no_idle    = 1'b0;
		sb = new();

		// Find a seed whose derived value is exactly the second modulus, so that
		// the second seed loads as zero. Newton steps invert the scale mod 2^32.
		inv = 32'(SEED_SCALE);
		repeat (5) inv = inv * (32'd2 - 32'(SEED_SCALE) * inv);

		// Seed settings in order: reset value (no write), zero, all ones,
		// first modulus (first seed stuck at zero), second seed stuck at zero,
		// two random seeds, and back to one.
		phase_seed[0] = SEED_RST;
		phase_seed[1] = '0;
		phase_seed[2] = '1;
		phase_seed[3] = SEED_W'(MOD_FIRST);
		phase_seed[4] = (SEED_W'(MOD_SECOND) - SEED_OFFSET) * inv;
		phase_seed[5] = $urandom;
		phase_seed[6] = $urandom;
		phase_seed[7] = 32'd1;

		directed = '{16'd0, 16'd1, 16'd2, 16'd3, 16'hFFFF, 16'hFFFE, 16'h8000, 16'h7FFF,
			16'h5555, 16'hAAAA, 16'h0100, 16'd10, 16'd7, 16'd0, 16'd1000, 16'd65521};

		repeat (8) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		for (int ph = 0; ph < PHASES; ph++) begin
			if (ph > 0) begin
				in_valid <= 1'b0;
				write_seed(phase_seed[ph]);
			end
			// One phase runs with no gaps. Another starts with a long output
			// hold-off while requests keep coming, so the block backs up.
			no_idle = (ph == 2);
			if (ph == 5) begin
				hold_left = HOLD_CYCLES;
			end
			if (ph == 0) begin
				foreach (directed[k]) send_request(directed[k]);
			end
			for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
				send_request(draw_limit());
			end
		end
		in_valid <= 1'b0;

		while (sb.pending() != 0) @(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);

		$display("Covered %0d requests over %0d seed settings with both seeds stuck at zero in turn",
			requests, PHASES);
		$display("and a %0d-cycle output hold-off; %0d results checked, %0d errors",
			HOLD_CYCLES, sb.checked, sb.errors);
		if (sb.errors == 0) begin
			$display("Simulation PASSED");
		end else begin
			$display("Simulation FAILED");
		end
		$finish;
	end

endmodule

@@ files.f @@
rtl/core/clr_pkg.sv
rtl/core/clr_alu.sv
rtl/core/clr_div.sv
rtl/core/combined_lcg_random_range_unit.sv
tb/sv/testbench.sv
